FILE: sv/tpt_pkg.sv
// Package for the turtle path tracker: widths, command codes, CORDIC tables.
// No dependencies.
package tpt_pkg;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
	localparam logic [16:0] HEADING_FULL = 17'd92160;
	localparam logic [16:0] HEADING_QUARTER = 17'd23040;

	localparam logic [1:0] FUNC_FWD = 2'd0;
	localparam logic [1:0] FUNC_LEFT = 2'd1;
	localparam logic [1:0] FUNC_RIGHT = 2'd2;
	localparam logic [1:0] FUNC_GOTO = 2'd3;

	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_START_HEADING = 2'd2;

	localparam logic signed [34:0] ROT_GAIN = 35'sd652032874;
	localparam logic [23:0] VEC_GAIN = 24'd10188014;
	localparam logic [40:0] PATH_MAX = {1'b0, {40{1'b1}}};

	// atan(2^-i), units of 2^-22 degree
	function automatic logic signed [34:0] atan_lut(input logic [STEP_W-1:0] i);
		logic signed [34:0] r;
		case (i)
			0: r = 35'sd188743680;  1: r = 35'sd111421900;
			2: r = 35'sd58872272;   3: r = 35'sd29884485;
			4: r = 35'sd15000234;   5: r = 35'sd7507429;
			6: r = 35'sd3754631;    7: r = 35'sd1877430;
			8: r = 35'sd938729;     9: r = 35'sd469366;
			10: r = 35'sd234683;    11: r = 35'sd117342;
			12: r = 35'sd58671;     13: r = 35'sd29335;
			14: r = 35'sd14668;     15: r = 35'sd7334;
			16: r = 35'sd3667;      17: r = 35'sd1833;
			18: r = 35'sd917;       19: r = 35'sd458;
			20: r = 35'sd229;       21: r = 35'sd115;
			22: r = 35'sd57;        23: r = 35'sd29;
			24: r = 35'sd14;        25: r = 35'sd7;
			26: r = 35'sd4;         27: r = 35'sd2;
			28: r = 35'sd1;
			default: r = 35'sd0;
		endcase
		return r;
	endfunction
endpackage

FILE: sv/turtle_path_tracker_top.sv
// Top level of the turtle path tracker: sequencer around one shared CORDIC
// shift-add unit and a multiplier shared by both move products. Depends on tpt_pkg.
//
// Usage:
//  - s_axis carries one command beat: tdata = {target_y, target_x, turn_amount,
//    distance, func}, zero padded to 112 bits.
//  - m_axis returns one result beat per command: tdata = {total_path,
//    heading_now, pos_y, pos_x}, padded to 128 bits.
//  - cfg_we/cfg_index/cfg_data write start_x, start_y, start_heading; each write
//    also loads the live position or heading. Write only while idle.
// Timing:
//  - m_axis_tvalid rises once a turn has wrapped the heading into range, and
//    after the vectoring pass of a go-to. Forward runs a quadrant reduction, a
//    rotation pass, two multiplies and a vectoring pass. Both CORDIC passes
//    iterate CORDIC_STEPS times on one shared shift-add unit, which sets the
//    rate.
//  - One command is in flight at a time; s_axis_tready is low while busy and
//    rises the cycle after the result beat is taken.
// Reset and stall:
//  - arst_n clears position, heading and path length to zero.
//  - While m_axis_tready is low the result is held and no new beat is taken.
module turtle_path_tracker_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[1:0], distance[25:2], turn_amount[43:26], target_x[75:44], target_y[107:76]
	input  logic [111:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x[31:0], pos_y[63:32], heading_now[80:64], total_path[120:81]
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import tpt_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TURN = 4'd1;
	localparam logic [3:0] ST_WRAP = 4'd2;
	localparam logic [3:0] ST_QUAD = 4'd3;
	localparam logic [3:0] ST_ROT = 4'd4;
	localparam logic [3:0] ST_MULX = 4'd5;
	localparam logic [3:0] ST_MULY = 4'd6;
	localparam logic [3:0] ST_MOVE = 4'd7;
	localparam logic [3:0] ST_VEC = 4'd8;
	localparam logic [3:0] ST_LEN = 4'd9;
	localparam logic [3:0] ST_ACC = 4'd10;
	localparam logic [3:0] ST_OUT = 4'd11;

	logic [3:0] state_q;
	logic signed [31:0] cur_x_q, cur_y_q;
	logic [16:0] heading_q;
	logic [40:0] path_q;
	logic [1:0] func_q;
	logic signed [23:0] dist_q;
	logic signed [18:0] turn_q;
	logic signed [31:0] tx_q, ty_q;
	logic [1:0] quad_q;
	logic [16:0] hres_q;
	// shared CORDIC datapath
	logic signed [38:0] cx_q, cy_q, cz_q;
	logic [STEP_W-1:0] step_q;
	logic signed [34:0] cos_q, sin_q;
	logic signed [59:0] prod_q;
	logic signed [33:0] nx_q;
	logic [63:0] len_q;

	logic [1:0] in_func;
	logic signed [23:0] in_dist;
	logic signed [17:0] in_turn;
	logic signed [31:0] in_tx, in_ty;
	assign in_func = s_axis_tdata[1:0];
	assign in_dist = s_axis_tdata[25:2];
	assign in_turn = s_axis_tdata[43:26];
	assign in_tx   = s_axis_tdata[75:44];
	assign in_ty   = s_axis_tdata[107:76];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {7'd0, path_q[39:0], heading_q, cur_y_q, cur_x_q};

	// one CORDIC micro-step
	logic signed [38:0] xs, ys;
	logic rot_dir;
	assign xs = cx_q >>> step_q;
	assign ys = cy_q >>> step_q;
	assign rot_dir = (state_q == ST_ROT) ? (cz_q >= 0) : !(cy_q > 0);

	// saturate a 34-bit sum into 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'sh7fffffff;
		if (v < -34'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic signed [33:0] dx_w, dy_w;
	logic signed [59:0] mul_w;
	logic signed [59:0] rnd_w;
	logic signed [33:0] dlt_w;
	logic signed [18:0] hsum_w;
	always_comb begin
		// shared multiplier: cosine product first, sine product in the move step
		mul_w = (state_q == ST_MULY) ? 60'(dist_q) * 60'(cos_q) : 60'(dist_q) * 60'(sin_q);
		rnd_w = (prod_q + 60'sd536870912) >>> 30;
		dlt_w = rnd_w[33:0];
		hsum_w = 19'($signed({2'b0, heading_q})) + turn_q;
		dx_w = 34'(nx_q) - 34'(cur_x_q);
		dy_w = 34'(ty_q) - 34'(cur_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
			heading_q <= '0;
			path_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// config writes load live state directly
					if (cfg_we) begin
						case (cfg_index)
							REG_START_X: cur_x_q <= cfg_data;
							REG_START_Y: cur_y_q <= cfg_data;
							REG_START_HEADING: heading_q <= (cfg_data[16:0] >= HEADING_FULL) ?
								cfg_data[16:0] - HEADING_FULL : cfg_data[16:0];
							default: ;
						endcase
					end
					if (s_axis_tvalid) begin
						func_q <= in_func;
						dist_q <= in_dist;
						turn_q <= (in_func == FUNC_RIGHT) ? -19'(in_turn) : 19'(in_turn);
						tx_q <= in_tx;
						ty_q <= in_ty;
						case (in_func)
							FUNC_FWD: state_q <= ST_QUAD;
							FUNC_GOTO: state_q <= ST_MOVE;
							default: state_q <= ST_TURN;
						endcase
						hres_q <= heading_q;
						quad_q <= 2'd0;
					end
				end
				ST_TURN: begin
					// heading + turn lies in [-131072, 223232): bring it into [0, 131072)
					if (hsum_w < -19'sd92160) heading_q <= 17'(hsum_w + 19'sd184320);
					else if (hsum_w < 0) heading_q <= 17'(hsum_w + 19'sd92160);
					else if (hsum_w >= 19'sd92160) heading_q <= 17'(hsum_w - 19'sd92160);
					else heading_q <= hsum_w[16:0];
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					if (heading_q >= HEADING_FULL) heading_q <= heading_q - HEADING_FULL;
					else state_q <= ST_OUT;
				end
				ST_QUAD: begin
					// reduce heading to its quadrant residue, one subtract per cycle
					if (hres_q >= HEADING_QUARTER) begin
						hres_q <= hres_q - HEADING_QUARTER;
						quad_q <= quad_q + 2'd1;
					end else begin
						cx_q <= 39'(ROT_GAIN);
						cy_q <= '0;
						cz_q <= 39'(hres_q) <<< 14;
						step_q <= '0;
						state_q <= ST_ROT;
					end
				end
				ST_ROT, ST_VEC: begin
					if (rot_dir) begin
						cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - 39'(atan_lut(step_q));
					end else begin
						cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + 39'(atan_lut(step_q));
					end
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= (state_q == ST_ROT) ? ST_MULX : ST_LEN;
					end
				end
				ST_MULX: begin
					case (quad_q)
						2'd0: begin cos_q <= 35'(cx_q); sin_q <= 35'(cy_q); end
						2'd1: begin cos_q <= -35'(cy_q); sin_q <= 35'(cx_q); end
						2'd2: begin cos_q <= -35'(cx_q); sin_q <= -35'(cy_q); end
						default: begin cos_q <= 35'(cy_q); sin_q <= -35'(cx_q); end
					endcase
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					prod_q <= mul_w;
					state_q <= ST_MOVE;
					func_q <= FUNC_LEFT;
				end
				ST_MOVE: begin
					if (func_q == FUNC_LEFT) begin
						// x delta is ready; start y product
						nx_q <= 34'(sat32(34'(cur_x_q) + dlt_w));
						prod_q <= mul_w;
						func_q <= FUNC_RIGHT;
					end else begin
						if (func_q == FUNC_RIGHT) ty_q <= sat32(34'(cur_y_q) - dlt_w);
						else nx_q <= 34'(tx_q);
						func_q <= FUNC_GOTO;
						state_q <= ST_ACC;
						step_q <= '0;
					end
				end
				ST_ACC: begin
					// load vectoring input
					cx_q <= 39'(dx_w < 0 ? -dx_w : dx_w) <<< 4;
					cy_q <= 39'(dy_w < 0 ? -dy_w : dy_w) <<< 4;
					cz_q <= '0;
					step_q <= '0;
					state_q <= ST_VEC;
				end
				ST_LEN: begin
					if (func_q == FUNC_GOTO) begin
						len_q <= (64'(cx_q < 0 ? 39'sd0 : cx_q) * 64'(VEC_GAIN)
							+ 64'd134217728) >> 28;
						func_q <= FUNC_FWD;
					end else begin
						path_q <= (path_q + 41'(len_q[40:0]) > PATH_MAX || len_q[63:41] != 0)
							? PATH_MAX : path_q + 41'(len_q[40:0]);
						cur_x_q <= nx_q[31:0];
						cur_y_q <= ty_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("busy and idle at once");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> heading_q < HEADING_FULL) else $error("heading out of range");
`endif
endmodule
